@@ rtl/scpq_pkg.sv @@
// Shared types and constants of the serial command parser and message queue.
// Holds the operation codes, message codes, command characters and the push request.
// No dependencies; every other file of the block but scpq_if.sv imports it.
package scpq_pkg;

	// Operation codes of the input channel.
	localparam logic [1:0] OP_BYTE  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// Message codes stored in the ring.
	localparam logic [3:0] MSG_ACK           = 4'd0;
	localparam logic [3:0] MSG_SENSOR_LIST   = 4'd1;
	localparam logic [3:0] MSG_SENSOR_WRITE  = 4'd2;
	localparam logic [3:0] MSG_SENSOR_ERASE  = 4'd3;
	localparam logic [3:0] MSG_CHANNEL_READ  = 4'd4;
	localparam logic [3:0] MSG_CHANNEL_SET   = 4'd5;
	localparam logic [3:0] MSG_MODE_SEARCH   = 4'd6;
	localparam logic [3:0] MSG_MODE_RECEIVE  = 4'd7;
	localparam logic [3:0] MSG_MODE_INVENT   = 4'd8;
	localparam logic [3:0] MSG_MODE_DEBUG    = 4'd9;
	localparam logic [3:0] MSG_TIMEOUT_READ  = 4'd10;
	localparam logic [3:0] MSG_TIMEOUT_SET   = 4'd11;

	// Command characters.
	localparam logic [7:0] CH_AT   = 8'h40;
	localparam logic [7:0] CH_BANG = 8'h21;
	localparam logic [7:0] CH_S    = 8'h53;
	localparam logic [7:0] CH_C    = 8'h43;
	localparam logic [7:0] CH_M    = 8'h4D;
	localparam logic [7:0] CH_T    = 8'h54;
	localparam logic [7:0] CH_W    = 8'h57;
	localparam logic [7:0] CH_E    = 8'h45;
	localparam logic [7:0] CH_L    = 8'h4C;
	localparam logic [7:0] CH_R    = 8'h52;
	localparam logic [7:0] CH_I    = 8'h49;
	localparam logic [7:0] CH_D    = 8'h44;

	// Argument bytes needed by the capturing commands.
	localparam logic [2:0] ARGS_LONG  = 3'd4;
	localparam logic [2:0] ARGS_SHORT = 3'd1;

	// Ring push request from the parser for one byte.
	typedef struct packed {
		logic       ack;   // push an acknowledge first
		logic       cmd;   // push a finished command
		logic [3:0] code;  // code of the finished command
	} push_req_t;

endpackage

@@ rtl/scpq_if.sv @@
// Valid/ready channel interfaces of the serial command parser and message queue.
// scpq_cmd_if carries input items, scpq_msg_if carries result items.
// No dependencies.
interface scpq_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] rx_byte;

	modport source (output valid, output operation, output rx_byte, input ready);
	modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

interface scpq_msg_if;
	logic        valid;
	logic        ready;
	logic        radio_restart;
	logic        msg_valid;
	logic [3:0]  msg_code;
	logic [31:0] arg_value;
	logic        overflow;

	modport source (output valid, output radio_restart, output msg_valid, output msg_code,
		output arg_value, output overflow, input ready);
	modport sink (input valid, input radio_restart, input msg_valid, input msg_code,
		input arg_value, input overflow, output ready);
endinterface

@@ rtl/scpq_parser.sv @@
// Two-letter command parser with argument capture.
// Depends on scpq_pkg for the characters, message codes and push request type.
module scpq_parser
	import scpq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [7:0]  rx_byte,
	output push_req_t   push,
	output logic [31:0] arg_value
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SENSOR,
		ST_SENSOR_WRITE,
		ST_SENSOR_ERASE,
		ST_CHANNEL,
		ST_CHANNEL_SET,
		ST_MODE,
		ST_TIMEOUT,
		ST_TIMEOUT_SET
	} parse_state_t;

	parse_state_t state_q, state_d;
	logic [2:0]   count_q, count_d;
	logic [7:0]   store_q [4];
	logic         store_we;
	logic [2:0]   count_inc;
	logic [2:0]   need;
	logic [3:0]   cap_code;
	logic         capturing;
	push_req_t    push_d;

	assign count_inc = count_q + 3'd1;
	assign arg_value = {store_q[3], store_q[2], store_q[1], store_q[0]};

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		store_we    = 1'b0;
		need        = ARGS_SHORT;
		cap_code    = MSG_CHANNEL_SET;
		capturing   = 1'b0;
		push_d.ack  = (rx_byte == CH_BANG);
		push_d.cmd  = 1'b0;
		push_d.code = MSG_ACK;
		case (state_q)
			ST_IDLE: begin
				if (rx_byte == CH_S) state_d = ST_SENSOR;
				else if (rx_byte == CH_C) state_d = ST_CHANNEL;
				else if (rx_byte == CH_M) state_d = ST_MODE;
				else if (rx_byte == CH_T) state_d = ST_TIMEOUT;
			end
			ST_SENSOR: begin
				state_d = ST_IDLE;
				if (rx_byte == CH_W) begin
					state_d = ST_SENSOR_WRITE;
					count_d = '0;
				end else if (rx_byte == CH_E) begin
					state_d = ST_SENSOR_ERASE;
					count_d = '0;
				end else if (rx_byte == CH_L) begin
					push_d.cmd  = 1'b1;
					push_d.code = MSG_SENSOR_LIST;
				end
			end
			ST_SENSOR_WRITE: begin
				capturing = 1'b1;
				need      = ARGS_LONG;
				cap_code  = MSG_SENSOR_WRITE;
			end
			ST_SENSOR_ERASE: begin
				capturing = 1'b1;
				need      = ARGS_LONG;
				cap_code  = MSG_SENSOR_ERASE;
			end
			ST_CHANNEL: begin
				state_d = ST_IDLE;
				if (rx_byte == CH_S) begin
					state_d = ST_CHANNEL_SET;
					count_d = '0;
				end else if (rx_byte == CH_R) begin
					push_d.cmd  = 1'b1;
					push_d.code = MSG_CHANNEL_READ;
				end
			end
			ST_CHANNEL_SET: begin
				capturing = 1'b1;
				cap_code  = MSG_CHANNEL_SET;
			end
			ST_MODE: begin
				state_d = ST_IDLE;
				if (rx_byte == CH_S) begin
					push_d.cmd  = 1'b1;
					push_d.code = MSG_MODE_SEARCH;
				end else if (rx_byte == CH_R) begin
					push_d.cmd  = 1'b1;
					push_d.code = MSG_MODE_RECEIVE;
				end else if (rx_byte == CH_I) begin
					push_d.cmd  = 1'b1;
					push_d.code = MSG_MODE_INVENT;
				end else if (rx_byte == CH_D) begin
					push_d.cmd  = 1'b1;
					push_d.code = MSG_MODE_DEBUG;
				end
			end
			ST_TIMEOUT: begin
				state_d = ST_IDLE;
				if (rx_byte == CH_S) begin
					state_d = ST_TIMEOUT_SET;
					count_d = '0;
				end else if (rx_byte == CH_R) begin
					push_d.cmd  = 1'b1;
					push_d.code = MSG_TIMEOUT_READ;
				end
			end
			ST_TIMEOUT_SET: begin
				capturing = 1'b1;
				cap_code  = MSG_TIMEOUT_SET;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// Argument capture: store the byte, and finish once enough bytes are in.
		if (capturing) begin
			store_we = 1'b1;
			count_d  = count_inc;
			if (count_inc >= need) begin
				state_d     = ST_IDLE;
				push_d.cmd  = 1'b1;
				push_d.code = cap_code;
			end
		end
	end

	assign push.ack  = en & push_d.ack;
	assign push.cmd  = en & push_d.cmd;
	assign push.code = push_d.code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			for (int i = 0; i < 4; i++) store_q[i] <= '0;
		end else if (en) begin
			state_q <= state_d;
			count_q <= count_d;
			if (store_we) store_q[count_q[1:0]] <= rx_byte;
		end
	end

endmodule

@@ rtl/serial_command_parser_queue_unit.sv @@
// Serial command parser with a message queue held in a synchronous ring memory.
// Depends on scpq_pkg, the channel interfaces in scpq_if.sv and scpq_parser.
//
// Usage: every transfer on the cmd channel carries an operation. Operation 0 hands
// one received byte to the two-letter parser, operation 1 reads one queued message
// and operation 2 clears the queue. Every cmd transfer yields exactly one transfer
// on the msg channel, in order. A received '@' raises radio_restart in its result.
// The queue holds at most QUEUE_DEPTH-1 codes; a push into a full queue is dropped
// and the result of that transfer shows overflow.
// Each result passes the synchronous read of the ring memory and then the output
// register before it is offered.
// Throughput: one transfer per cycle while the receiver keeps up. A '!' byte
// that also completes a command pushes two codes; the ring has one write port,
// so the second write takes the next cycle, with cmd.ready low for that cycle.
// Reset clears the parser, the argument bytes, both ring indexes and the pipeline.
// The ring memory itself is not cleared; only written entries are ever read.
// When the receiver stalls, the output register holds its result and one further
// item is still accepted into the memory read stage; then cmd.ready drops.
module serial_command_parser_queue_unit
	import scpq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input logic         clk,
	input logic         arst_n,
	scpq_cmd_if.sink    cmd,
	scpq_msg_if.source  msg
);

	localparam int IW = $clog2(QUEUE_DEPTH);

	function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] idx);
		ring_next = (idx == IW'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
	endfunction

	// Ring memory, one write port and one registered read port.
	logic [3:0]    ring_mem [QUEUE_DEPTH];
	logic [3:0]    rd_q;
	logic          rd_en;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic [3:0]    wr_data;

	logic [IW-1:0] wr_idx_q, rd_idx_q;
	logic [IW-1:0] wr_idx1, wr_idx2;

	// Second write of a byte that pushed two codes.
	logic          pend_q;
	logic [IW-1:0] pend_addr_q;
	logic [3:0]    pend_code_q;

	logic        accept;
	logic        advance;
	logic        is_byte, is_read, is_clear;
	logic        full1, full2, ack_ok, cmd_ok, ovf;
	logic        not_empty;
	push_req_t   push;
	logic [31:0] arg_store;

	// Memory read stage.
	logic        valid_s1;
	logic        restart_s1;
	logic        msgv_s1;
	logic [31:0] arg_s1;
	logic        ovf_s1;

	// Output register.
	logic        out_valid_q;
	logic        restart_q;
	logic        msgv_q;
	logic [3:0]  code_q;
	logic [31:0] arg_q;
	logic        ovf_q;

	assign advance   = valid_s1 & (~out_valid_q | msg.ready);
	assign cmd.ready = ~pend_q & (~valid_s1 | advance);
	assign accept    = cmd.valid & cmd.ready;

	assign is_byte  = accept & (cmd.operation == OP_BYTE);
	assign is_read  = accept & (cmd.operation == OP_READ);
	assign is_clear = accept & (cmd.operation == OP_CLEAR);

	scpq_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (is_byte),
		.rx_byte   (cmd.rx_byte),
		.push      (push),
		.arg_value (arg_store)
	);

	// The acknowledge goes in before the command; each checks for a full ring
	// against the write index left by the one before it.
	always_comb begin
		full1   = (ring_next(wr_idx_q) == rd_idx_q);
		ack_ok  = push.ack & ~full1;
		wr_idx1 = ack_ok ? ring_next(wr_idx_q) : wr_idx_q;
		full2   = (ring_next(wr_idx1) == rd_idx_q);
		cmd_ok  = push.cmd & ~full2;
		wr_idx2 = cmd_ok ? ring_next(wr_idx1) : wr_idx1;
		ovf     = (push.ack & full1) | (push.cmd & full2);
	end

	assign not_empty = (wr_idx_q != rd_idx_q);
	assign rd_en     = is_read & not_empty;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = wr_idx_q;
		wr_data = MSG_ACK;
		if (pend_q) begin
			wr_en   = 1'b1;
			wr_addr = pend_addr_q;
			wr_data = pend_code_q;
		end else if (ack_ok) begin
			wr_en   = 1'b1;
			wr_addr = wr_idx_q;
			wr_data = MSG_ACK;
		end else if (cmd_ok) begin
			wr_en   = 1'b1;
			wr_addr = wr_idx1;
			wr_data = push.code;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) ring_mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= ring_mem[rd_idx_q];
	end

	// Ring indexes and the pending second write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			pend_q   <= 1'b0;
		end else begin
			pend_q <= ack_ok & cmd_ok;
			if (is_clear) begin
				wr_idx_q <= '0;
				rd_idx_q <= '0;
			end else begin
				wr_idx_q <= wr_idx2;
				if (rd_en) rd_idx_q <= ring_next(rd_idx_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ack_ok & cmd_ok) begin
			pend_addr_q <= wr_idx1;
			pend_code_q <= push.code;
		end
	end

	// Memory read stage: the code arrives from the ring in the cycle after the read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			restart_s1 <= is_byte & (cmd.rx_byte == CH_AT);
			msgv_s1    <= rd_en;
			arg_s1     <= rd_en ? arg_store : '0;
			ovf_s1     <= is_byte & ovf;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (msg.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			restart_q <= restart_s1;
			msgv_q    <= msgv_s1;
			code_q    <= msgv_s1 ? rd_q : MSG_ACK;
			arg_q     <= arg_s1;
			ovf_q     <= ovf_s1;
		end
	end

	assign msg.valid         = out_valid_q;
	assign msg.radio_restart = restart_q;
	assign msg.msg_valid     = msgv_q;
	assign msg.msg_code      = code_q;
	assign msg.arg_value     = arg_q;
	assign msg.overflow      = ovf_q;

endmodule

@@ bench/scpq_checker.sv @@
// Checker for the serial command parser and message queue: watches both channels,
// keeps its own copy of the parser and ring state, and compares every result.
// Depends on scpq_pkg and the channel interfaces in scpq_if.sv.
module scpq_checker
	import scpq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	scpq_cmd_if  cmd,
	scpq_msg_if  msg,
	output int   mismatches,
	output int   outstanding,
	output int   compared,
	output int   drops
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IW = $clog2(QUEUE_DEPTH);

	typedef enum logic [3:0] {
		P_IDLE,
		P_SENSOR,
		P_SENSOR_WRITE,
		P_SENSOR_ERASE,
		P_CHANNEL,
		P_CHANNEL_SET,
		P_MODE,
		P_TIMEOUT,
		P_TIMEOUT_SET
	} parse_state_t;

	typedef struct packed {
		logic        restart;
		logic        found;
		logic [3:0]  code;
		logic [31:0] args;
		logic        dropped;
	} reply_t;

	parse_state_t pstate;
	logic [2:0]   arg_count;
	logic [7:0]   arg_bytes [4];
	logic [3:0]   ring [QUEUE_DEPTH];
	logic [IW-1:0] wr_ptr;
	logic [IW-1:0] rd_ptr;
	logic         drop_flag;
	reply_t       reply_fifo [$];
	int           err_count;
	int           seen_count;
	int           drop_count;

	assign mismatches = err_count;
	assign compared   = seen_count;
	assign drops      = drop_count;

	function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] p);
		return (p == IW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// The ring keeps one slot free; a push that would close the gap is lost.
	function automatic void ring_push(input logic [3:0] code);
		logic [IW-1:0] nxt;
		nxt = ring_next(wr_ptr);
		if (nxt == rd_ptr) begin
			drop_flag = 1'b1;
		end else begin
			ring[wr_ptr] = code;
			wr_ptr = nxt;
		end
	endfunction

	function automatic void capture_arg(input logic [7:0] b, input logic [2:0] need,
		input logic [3:0] code);
		arg_bytes[arg_count[1:0]] = b;
		arg_count = arg_count + 3'd1;
		if (arg_count >= need) begin
			pstate = P_IDLE;
			ring_push(code);
		end
	endfunction

	function automatic void parse_byte(input logic [7:0] b);
		case (pstate)
			P_IDLE: begin
				if (b == CH_S) pstate = P_SENSOR;
				else if (b == CH_C) pstate = P_CHANNEL;
				else if (b == CH_M) pstate = P_MODE;
				else if (b == CH_T) pstate = P_TIMEOUT;
			end
			P_SENSOR: begin
				pstate = P_IDLE;
				if (b == CH_W) begin
					pstate = P_SENSOR_WRITE;
					arg_count = '0;
				end else if (b == CH_E) begin
					pstate = P_SENSOR_ERASE;
					arg_count = '0;
				end else if (b == CH_L) begin
					ring_push(MSG_SENSOR_LIST);
				end
			end
			P_SENSOR_WRITE: capture_arg(b, ARGS_LONG, MSG_SENSOR_WRITE);
			P_SENSOR_ERASE: capture_arg(b, ARGS_LONG, MSG_SENSOR_ERASE);
			P_CHANNEL: begin
				pstate = P_IDLE;
				if (b == CH_S) begin
					pstate = P_CHANNEL_SET;
					arg_count = '0;
				end else if (b == CH_R) begin
					ring_push(MSG_CHANNEL_READ);
				end
			end
			P_CHANNEL_SET: capture_arg(b, ARGS_SHORT, MSG_CHANNEL_SET);
			P_MODE: begin
				pstate = P_IDLE;
				if (b == CH_S) ring_push(MSG_MODE_SEARCH);
				else if (b == CH_R) ring_push(MSG_MODE_RECEIVE);
				else if (b == CH_I) ring_push(MSG_MODE_INVENT);
				else if (b == CH_D) ring_push(MSG_MODE_DEBUG);
			end
			P_TIMEOUT: begin
				pstate = P_IDLE;
				if (b == CH_S) begin
					pstate = P_TIMEOUT_SET;
					arg_count = '0;
				end else if (b == CH_R) begin
					ring_push(MSG_TIMEOUT_READ);
				end
			end
			P_TIMEOUT_SET: capture_arg(b, ARGS_SHORT, MSG_TIMEOUT_SET);
			default: pstate = P_IDLE;
		endcase
	endfunction

	// Advances the shadow state by one command transfer and returns its result.
	function automatic reply_t apply_command(input logic [1:0] op, input logic [7:0] b);
		reply_t r;
		r = '0;
		drop_flag = 1'b0;
		case (op)
			OP_BYTE: begin
				r.restart = (b == CH_AT);
				if (b == CH_BANG) ring_push(MSG_ACK);
				parse_byte(b);
			end
			OP_READ: begin
				if (wr_ptr != rd_ptr) begin
					r.found = 1'b1;
					r.code = ring[rd_ptr];
					r.args = {arg_bytes[3], arg_bytes[2], arg_bytes[1], arg_bytes[0]};
					rd_ptr = ring_next(rd_ptr);
				end
			end
			OP_CLEAR: begin
				wr_ptr = '0;
				rd_ptr = '0;
			end
			default: ;
		endcase
		r.dropped = drop_flag;
		return r;
	endfunction

	always @(posedge clk) begin : monitor
		reply_t got;
		reply_t want;
		if (!arst_n) begin
			pstate = P_IDLE;
			arg_count = '0;
			arg_bytes = '{default: '0};
			ring = '{default: '0};
			wr_ptr = '0;
			rd_ptr = '0;
			reply_fifo.delete();
			err_count = 0;
			seen_count = 0;
			drop_count = 0;
		end else begin
			// Results first: a command transfer on this edge cannot own a result yet.
			if (msg.valid && msg.ready) begin
				got = {msg.radio_restart, msg.msg_valid, msg.msg_code, msg.arg_value,
					msg.overflow};
				seen_count++;
				if (got.dropped === 1'b1) drop_count++;
				if (reply_fifo.size() == 0) begin
					err_count++;
					$error("result transfer with no command outstanding");
				end else begin
					want = reply_fifo.pop_front();
					if (got.restart !== want.restart) begin
						err_count++;
						$error("radio_restart: expected %0d, got %0d", want.restart, got.restart);
					end
					if (got.found !== want.found) begin
						err_count++;
						$error("msg_valid: expected %0d, got %0d", want.found, got.found);
					end
					if (got.code !== want.code) begin
						err_count++;
						$error("msg_code: expected %0d, got %0d", want.code, got.code);
					end
					if (got.args !== want.args) begin
						err_count++;
						$error("arg_value: expected %08h, got %08h", want.args, got.args);
					end
					if (got.dropped !== want.dropped) begin
						err_count++;
						$error("overflow: expected %0d, got %0d", want.dropped, got.dropped);
					end
				end
			end
			if (cmd.valid && cmd.ready) begin
				reply_fifo.push_back(apply_command(cmd.operation, cmd.rx_byte));
			end
		end
		outstanding <= reply_fifo.size();
	end

endmodule

@@ bench/tb_serial_command_parser_queue_unit.sv @@
// Top of the testbench for the serial command parser and message queue.
// Drives command transfers and result back-pressure; scpq_checker does the comparing.
// Depends on scpq_pkg, scpq_if.sv, scpq_checker and the block itself.
module tb_serial_command_parser_queue_unit
	import scpq_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1000;
	localparam int LONG_HOLD    = 300;   // receiver hold-off, long enough to stall the input
	localparam int IDLE_LIMIT   = 2000;  // cycles without any transfer before giving up
	localparam int TAIL_CYCLES  = 20;    // the block answers via its memory read stage and output register

	// The one operation code with no meaning; the block answers it with all zeros.
	localparam logic [1:0] OP_NONE = 2'd3;

	logic clk;
	logic arst_n;

	scpq_cmd_if cmd ();
	scpq_msg_if msg ();

	int mismatches;
	int outstanding;
	int compared;
	int drops;

	// Shared between the command side and the result side.
	int items_sent  = 0;
	int hold_requests = 0;
	bit src_quiet  = 1'b0;
	bit sink_quiet = 1'b0;

	serial_command_parser_queue_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.msg    (msg)
	);

	scpq_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.msg         (msg),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.compared    (compared),
		.drops       (drops)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Gap after a command transfer: mostly back to back, sometimes a few cycles,
	// now and then a long pause. During quiet stretches there are no gaps at all.
	function automatic int source_gap();
		int r;
		if (src_quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Argument bytes are mostly random, with a bias toward bytes that also mean
	// something to the parser so that the ack-inside-a-capture case comes up often.
	function automatic logic [7:0] arg_byte();
		case ($urandom_range(0, 9))
			0: return CH_BANG;
			1: return CH_AT;
			2: return ($urandom_range(0, 1) != 0) ? 8'h00 : 8'hFF;
			3: return CH_S;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] lead_letter();
		case ($urandom_range(0, 3))
			0: return CH_S;
			1: return CH_C;
			2: return CH_M;
			default: return CH_T;
		endcase
	endfunction

	// One command transfer. Valid stays high when the next transfer follows at once,
	// so it is never lowered and raised within the same edge.
	task automatic send_item(input logic [1:0] op, input logic [7:0] b);
		int gap;
		cmd.valid     <= 1'b1;
		cmd.operation <= op;
		cmd.rx_byte   <= b;
		do @(posedge clk); while (!cmd.ready);
		items_sent++;
		gap = source_gap();
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item(OP_BYTE, b);
	endtask

	// Sends the byte sequence of one complete command, arguments included.
	task automatic send_command(input logic [3:0] code);
		case (code)
			MSG_ACK: send_byte(CH_BANG);
			MSG_SENSOR_LIST: begin
				send_byte(CH_S);
				send_byte(CH_L);
			end
			MSG_SENSOR_WRITE, MSG_SENSOR_ERASE: begin
				send_byte(CH_S);
				send_byte((code == MSG_SENSOR_WRITE) ? CH_W : CH_E);
				repeat (4) send_byte(arg_byte());
			end
			MSG_CHANNEL_READ: begin
				send_byte(CH_C);
				send_byte(CH_R);
			end
			MSG_CHANNEL_SET: begin
				send_byte(CH_C);
				send_byte(CH_S);
				send_byte(arg_byte());
			end
			MSG_MODE_SEARCH, MSG_MODE_RECEIVE, MSG_MODE_INVENT, MSG_MODE_DEBUG: begin
				send_byte(CH_M);
				case (code)
					MSG_MODE_SEARCH:  send_byte(CH_S);
					MSG_MODE_RECEIVE: send_byte(CH_R);
					MSG_MODE_INVENT:  send_byte(CH_I);
					default:          send_byte(CH_D);
				endcase
			end
			MSG_TIMEOUT_READ: begin
				send_byte(CH_T);
				send_byte(CH_R);
			end
			default: begin
				send_byte(CH_T);
				send_byte(CH_S);
				send_byte(arg_byte());
			end
		endcase
	endtask

	// Stops offering and waits until the checker has seen every result it expects.
	// The checker publishes its count through a register, so a clock edge passes first.
	task automatic wait_all_replies();
		cmd.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Result side: random ready with short stalls, occasional longer ones, quiet
	// stretches with ready held high, and a long hold-off whenever one is requested.
	initial begin : result_side
		int stall_left;
		int holds_done;
		stall_left = 0;
		holds_done = 0;
		msg.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				msg.ready <= 1'b0;
			end else if (holds_done != hold_requests) begin
				holds_done++;
				stall_left = LONG_HOLD;
				msg.ready <= 1'b0;
			end else if (!sink_quiet && $urandom_range(0, 99) < 3) begin
				stall_left = $urandom_range(10, 40);
				msg.ready <= 1'b0;
			end else begin
				msg.ready <= sink_quiet || ($urandom_range(0, 99) < 70);
			end
		end
	end

	// Watchdog: gives up when no transfer happens on either channel for too long.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((cmd.valid && cmd.ready) || (msg.valid && msg.ready)) idle_cycles = 0;
			else idle_cycles++;
		end
		$display("Timeout: no transfer for %0d cycles, %0d results outstanding",
			IDLE_LIMIT, outstanding);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : stimulus
		int r;
		int round;
		int limit;
		arst_n = 1'b0;
		cmd.valid     <= 1'b0;
		cmd.operation <= OP_BYTE;
		cmd.rx_byte   <= 8'h00;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: restart byte, a lone ack, read of the ack and an empty read, the
		// unused operation, a sensor list, a sensor write with extreme argument bytes, an ack
		// byte that also finishes a timeout set (two pushes from one byte), an unknown second
		// letter, a mode command, a read, a clear, a read after it and a channel read.
		send_byte(CH_AT);
		send_byte(CH_BANG);
		send_item(OP_READ, 8'hFF);
		send_item(OP_READ, 8'h00);
		send_item(OP_NONE, 8'hFF);
		send_byte(CH_S);
		send_byte(CH_L);
		send_byte(CH_S);
		send_byte(CH_W);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hA5);
		send_byte(8'h5A);
		send_byte(CH_T);
		send_byte(CH_S);
		send_byte(CH_BANG);
		send_byte(CH_S);
		send_byte(8'h58);
		send_byte(CH_M);
		send_byte(CH_D);
		send_item(OP_READ, 8'h00);
		send_item(OP_CLEAR, 8'hFF);
		send_item(OP_READ, 8'h00);
		send_byte(CH_C);
		send_byte(CH_R);
		wait_all_replies();

		// Random part: mostly complete commands with random arguments, mixed with
		// reads, clears, noise bytes and broken sequences. Commands outnumber reads,
		// so the ring fills up and overflows regularly.
		limit = items_sent + RANDOM_ITEMS;
		round = 0;
		while (items_sent < limit) begin
			round++;
			if (round % 60 == 0) begin
				src_quiet  = ($urandom_range(0, 3) == 0);
				sink_quiet = ($urandom_range(0, 3) == 0);
			end
			// Hold the receiver off while commands keep coming, so the pipeline
			// fills and the block has to stall its input.
			if (round == 120) begin
				src_quiet = 1'b1;
				hold_requests++;
			end
			if (round % 200 == 199) wait_all_replies();

			r = $urandom_range(0, 99);
			if (r < 50) begin
				send_command(4'($urandom_range(0, 11)));
			end else if (r < 66) begin
				repeat ($urandom_range(1, 3)) send_item(OP_READ, 8'($urandom_range(0, 255)));
			end else if (r < 70) begin
				repeat ($urandom_range(8, 20)) send_item(OP_READ, 8'($urandom_range(0, 255)));
			end else if (r < 73) begin
				send_item(OP_CLEAR, 8'($urandom_range(0, 255)));
			end else if (r < 76) begin
				send_item(OP_NONE, 8'($urandom_range(0, 255)));
			end else if (r < 88) begin
				send_byte(8'($urandom_range(0, 255)));
			end else if (r < 95) begin
				// A group letter followed by an arbitrary byte.
				send_byte(lead_letter());
				send_byte(8'($urandom_range(0, 255)));
			end else begin
				// A capture cut short: the next command's bytes become arguments.
				send_byte(CH_S);
				send_byte(($urandom_range(0, 1) != 0) ? CH_W : CH_E);
				repeat ($urandom_range(1, 3)) send_byte(arg_byte());
				send_command(4'($urandom_range(0, 11)));
			end
		end

		wait_all_replies();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d command transfers and compared %0d results;", items_sent, compared);
		$display("%0d results reported a message dropped on a full ring.", drops);
		if (mismatches == 0 && outstanding == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
